>>> src/rff_pkg.sv
// Package for the record field filter: sizes, code types and the transaction
// record that moves down the chain of slot cells. No dependencies.
package rff_pkg;

  localparam int FILTER_SLOTS  = 4;
  localparam int PATTERN_BYTES = 8;
  localparam int OFFSET_BITS   = 16;

  localparam int SLOT_W      = 2;
  localparam int SETUP_W     = 24;
  localparam int PATTERN_W   = 64;
  localparam int LEN_W       = 4;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int BYTE_IDX_W  = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;

  localparam logic [OFFSET_BITS-1:0] POS_LIMIT = '1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SLOT0_SETUP   = 3'd0,
    REG_SLOT1_SETUP   = 3'd1,
    REG_SLOT2_SETUP   = 3'd2,
    REG_SLOT3_SETUP   = 3'd3,
    REG_SLOT0_PATTERN = 3'd4,
    REG_SLOT1_PATTERN = 3'd5,
    REG_SLOT2_PATTERN = 3'd6,
    REG_SLOT3_PATTERN = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    OP_EQ   = 3'd0,
    OP_GE   = 3'd1,
    OP_GT   = 3'd2,
    OP_LE   = 3'd3,
    OP_LT   = 3'd4,
    OP_NE   = 3'd5,
    OP_SW   = 3'd6,
    OP_PASS = 3'd7
  } cmp_op_t;

  typedef enum logic [1:0] {
    ST_EQUAL   = 2'd0,
    ST_LESS    = 2'd1,
    ST_GREATER = 2'd2
  } cmp_status_t;

  // One record byte plus the verdict gathered from the cells passed so far.
  typedef struct packed {
    logic                   valid;
    logic [7:0]             data;
    logic                   last;
    logic                   cmp;    // position not saturated, byte is compared
    logic [OFFSET_BITS-1:0] pos;
    logic [OFFSET_BITS-1:0] rcv;    // bytes received including this one
    logic                   rej;
    logic [SLOT_W-1:0]      fslot;
    logic                   shrt;
  } item_t;

endpackage

>>> src/rff_cell.sv
// One filter slot cell: holds the slot's compare status and passes the
// transaction record on to the next cell. Depends on rff_pkg.
module rff_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic [rff_pkg::SLOT_W-1:0]     slot_id,
  input  logic [rff_pkg::SETUP_W-1:0]    setup,
  input  logic [rff_pkg::PATTERN_W-1:0]  pattern,
  input  rff_pkg::item_t                 item_in,
  output rff_pkg::item_t                 item_out
);

  rff_pkg::cmp_status_t             status;
  rff_pkg::cmp_status_t             status_next;
  rff_pkg::cmp_op_t                 op;
  rff_pkg::item_t                   item_next;
  logic                             slot_en;
  logic [rff_pkg::LEN_W-1:0]        len_raw;
  logic [rff_pkg::LEN_W-1:0]        len;
  logic [rff_pkg::OFFSET_BITS-1:0]  off;
  logic [rff_pkg::OFFSET_BITS-1:0]  k_full;
  logic [rff_pkg::BYTE_IDX_W-1:0]   kidx;
  logic [7:0]                       pbyte;
  logic                             in_field;
  logic                             fails;
  logic [rff_pkg::OFFSET_BITS:0]    field_end;

  always_comb begin
    slot_en = setup[23];
    op      = rff_pkg::cmp_op_t'(setup[22:20]);
    len_raw = setup[19:16];
    len     = (len_raw > rff_pkg::LEN_W'(rff_pkg::PATTERN_BYTES)) ?
              rff_pkg::LEN_W'(rff_pkg::PATTERN_BYTES) : len_raw;
    off     = rff_pkg::OFFSET_BITS'(setup[15:0]);
    k_full  = item_in.pos - off;
    kidx    = k_full[rff_pkg::BYTE_IDX_W-1:0];
    pbyte   = pattern[8*kidx +: 8];
    in_field = item_in.cmp && (item_in.pos >= off) &&
               (k_full < rff_pkg::OFFSET_BITS'(len));

    // memcmp style: only the first differing byte decides
    status_next = status;
    if (status == rff_pkg::ST_EQUAL && in_field) begin
      if (item_in.data < pbyte) begin
        status_next = rff_pkg::ST_LESS;
      end else if (item_in.data > pbyte) begin
        status_next = rff_pkg::ST_GREATER;
      end
    end

    unique case (op)
      rff_pkg::OP_EQ:   fails = (status_next != rff_pkg::ST_EQUAL);
      rff_pkg::OP_GE:   fails = (status_next == rff_pkg::ST_LESS);
      rff_pkg::OP_GT:   fails = (status_next != rff_pkg::ST_GREATER);
      rff_pkg::OP_LE:   fails = (status_next == rff_pkg::ST_GREATER);
      rff_pkg::OP_LT:   fails = (status_next != rff_pkg::ST_LESS);
      rff_pkg::OP_NE:   fails = (status_next == rff_pkg::ST_EQUAL);
      rff_pkg::OP_SW:   fails = (status_next != rff_pkg::ST_EQUAL);
      rff_pkg::OP_PASS: fails = 1'b0;
      default:          fails = 1'b0;
    endcase

    field_end = {1'b0, off} + (rff_pkg::OFFSET_BITS + 1)'(len);

    item_next = item_in;
    if (slot_en && fails && !item_in.rej) begin
      item_next.rej   = 1'b1;
      item_next.fslot = slot_id;
    end
    if (slot_en && (field_end > {1'b0, item_in.rcv})) begin
      item_next.shrt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status         <= rff_pkg::ST_EQUAL;
      item_out.valid <= 1'b0;
    end else if (en) begin
      item_out.valid <= item_in.valid;
      if (item_in.valid) begin
        status <= item_in.last ? rff_pkg::ST_EQUAL : status_next;
      end
    end
    if (en) begin
      item_out.data  <= item_next.data;
      item_out.last  <= item_next.last;
      item_out.cmp   <= item_next.cmp;
      item_out.pos   <= item_next.pos;
      item_out.rcv   <= item_next.rcv;
      item_out.rej   <= item_next.rej;
      item_out.fslot <= item_next.fslot;
      item_out.shrt  <= item_next.shrt;
    end
  end

endmodule

>>> src/record_field_filter.sv
// Record field filter: a record streams in one byte per cycle through a chain
// of FILTER_SLOTS slot cells, each updating its own compare status.
// Throughput: one byte per cycle; the chain stalls only while a result waits.
// The verdict of the last byte passes the FILTER_SLOTS cell registers, then the output register.
// Reset (rst, synchronous): all slots disabled, patterns zero, position zero,
// statuses equal, chain and output register empty.
module record_field_filter (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [rff_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [rff_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,   // [7:0] record_byte
  input  logic                             s_tlast,   // last_byte
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [7:0]                       m_tdata    // [0] rejected, [2:1] failing_slot,
                                                      // [3] short_record, [7:4] zero
);

  localparam int N = rff_pkg::FILTER_SLOTS;

  logic [rff_pkg::SETUP_W-1:0]      setup_reg   [N];
  logic [rff_pkg::PATTERN_W-1:0]    pattern_reg [N];
  logic [rff_pkg::OFFSET_BITS-1:0]  pos;
  rff_pkg::item_t                   link [N+1];
  rff_pkg::item_t                   tail;
  logic                             en;
  logic                             load;
  logic                             out_valid;
  logic                             out_rej;
  logic [rff_pkg::SLOT_W-1:0]       out_fslot;
  logic                             out_shrt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < N; s++) begin
        setup_reg[s]   <= '0;
        pattern_reg[s] <= '0;
      end
    end else if (cfg_we) begin
      for (int s = 0; s < N; s++) begin
        if (cfg_index == rff_pkg::CFG_INDEX_W'(int'(rff_pkg::REG_SLOT0_SETUP) + s)) begin
          setup_reg[s] <= cfg_data[rff_pkg::SETUP_W-1:0];
        end
        if (cfg_index == rff_pkg::CFG_INDEX_W'(int'(rff_pkg::REG_SLOT0_PATTERN) + s)) begin
          pattern_reg[s] <= cfg_data[rff_pkg::PATTERN_W-1:0];
        end
      end
    end
  end

  assign tail     = link[N];
  assign en       = !(tail.valid && tail.last && out_valid && !m_tready);
  assign s_tready = en;
  assign load     = en && tail.valid && tail.last;

  always_comb begin
    link[0].valid = s_tvalid;
    link[0].data  = s_tdata;
    link[0].last  = s_tlast;
    link[0].cmp   = (pos != rff_pkg::POS_LIMIT);
    link[0].pos   = pos;
    link[0].rcv   = (pos != rff_pkg::POS_LIMIT) ? pos + 1'b1 : pos;
    link[0].rej   = 1'b0;
    link[0].fslot = '0;
    link[0].shrt  = 1'b0;
  end

  // byte position, saturating
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (s_tvalid && s_tready) begin
      if (s_tlast) begin
        pos <= '0;
      end else if (pos != rff_pkg::POS_LIMIT) begin
        pos <= pos + 1'b1;
      end
    end
  end

  for (genvar s = 0; s < N; s++) begin : g_cell
    rff_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .slot_id  (rff_pkg::SLOT_W'(s)),
      .setup    (setup_reg[s]),
      .pattern  (pattern_reg[s]),
      .item_in  (link[s]),
      .item_out (link[s+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_rej   <= tail.rej;
      out_fslot <= tail.fslot;
      out_shrt  <= tail.shrt;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, out_shrt, out_fslot, out_rej};

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (tail.valid && tail.last && out_valid))
    else $error("input stalled without a waiting result");

  a_result_kept: assert property (@(posedge clk) disable iff (rst)
    load |=> m_tvalid)
    else $error("result lost on its way to the output register");

  a_pass_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[2:1] == '0))
    else $error("failing slot set on a passing record");

  a_pos_saturates: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !s_tlast && pos == rff_pkg::POS_LIMIT)
      |=> (pos == rff_pkg::POS_LIMIT))
    else $error("byte position wrapped");

endmodule
